// ===== hdl/bsfp_pkg.sv =====
// shared types, constants and elaboration-time functions of the brush stamp falloff block
package bsfp_pkg;

    localparam int D_W        = 18;
    localparam int ROOT_W     = 25;
    localparam int Q_W        = 17;
    localparam int SIZE_W     = 9;
    localparam int EXPO_W     = 12;
    localparam int OPAC_W     = 9;
    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int FRAC_PAIRS = 16;
    localparam int EXP_STEPS  = 16;
    localparam int LOG_STEPS  = 16;
    localparam int LATENCY    = 83;

    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic valid;
        logic hit;
    } bsfp_ctl_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE     = 3'd0,
        CFG_HARDNESS = 3'd1,
        CFG_OPACITY  = 3'd2,
        CFG_RED      = 3'd3,
        CFG_GREEN    = 3'd4,
        CFG_BLUE     = 3'd5
    } bsfp_cfg_idx_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        v     = val;
        res   = '0;
        bit_m = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bit_m) begin
                v   = v - (res + bit_m);
                res = (res >> 1) + bit_m;
            end else begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

    // repeated square roots of one half, q0.32
    function automatic logic [31:0] exp_root(input int idx);
        logic [63:0] r;
        r = 64'h8000_0000;
        for (int j = 1; j <= idx; j++) begin
            r = isqrt64(r << 32);
        end
        return r[31:0];
    endfunction

endpackage

// ===== hdl/bsfp_root.sv =====
// pipelined square root of the scaled distance and division by the stamp size
module bsfp_root
    import bsfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsfp_ctl_t         in_ctl,
    input  logic [D_W-1:0]    in_d,
    input  logic [SIZE_W-1:0] size,
    output bsfp_ctl_t         out_ctl,
    output logic [Q_W-1:0]    out_t
);

    localparam int SQ_N  = ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int DV_N  = Q_W;

    bsfp_ctl_t         sq_ctl_reg  [SQ_N];
    logic [D_W-1:0]    sq_d_reg    [SQ_N];
    logic [REM_W-1:0]  sq_rem_reg  [SQ_N];
    logic [ROOT_W-1:0] sq_root_reg [SQ_N];

    bsfp_ctl_t         dv_ctl_reg [DV_N];
    logic [SIZE_W-1:0] dv_rem_reg [DV_N];
    logic [Q_W-1:0]    dv_q_reg   [DV_N];
    logic [Q_W-1:0]    dv_lo_reg  [DV_N];

    // one root bit per stage
    for (genvar s = 0; s < SQ_N; s++) begin : g_sq
        localparam int P = SQ_N - 1 - s;
        bsfp_ctl_t         ctl_prev;
        logic [D_W-1:0]    d_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_head
            assign ctl_prev  = in_ctl;
            assign d_prev    = in_d;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_body
            assign ctl_prev  = sq_ctl_reg[s-1];
            assign d_prev    = sq_d_reg[s-1];
            assign rem_prev  = sq_rem_reg[s-1];
            assign root_prev = sq_root_reg[s-1];
        end

        if (P >= FRAC_PAIRS) begin : g_data
            assign pair = d_prev[2*(P-FRAC_PAIRS)+1 -: 2];
        end else begin : g_frac
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh = {rem_prev[REM_W-3:0], pair};
            trial  = {1'b0, root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_ctl_reg[s] <= '0;
            else
                sq_ctl_reg[s] <= ctl_prev;
        end

        always_ff @(posedge clk)
        begin
            sq_d_reg[s]    <= d_prev;
            sq_rem_reg[s]  <= rem_next;
            sq_root_reg[s] <= root_next;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < DV_N; j++) begin : g_dv
        localparam int B = DV_N - 1 - j;
        bsfp_ctl_t         ctl_prev;
        logic [SIZE_W-1:0] rem_prev;
        logic [Q_W-1:0]    q_prev;
        logic [Q_W-1:0]    lo_prev;
        logic [SIZE_W:0]   rem_sh;
        logic [SIZE_W-1:0] rem_next;
        logic              q_bit;

        if (j == 0) begin : g_head
            assign ctl_prev = sq_ctl_reg[SQ_N-1];
            assign rem_prev = SIZE_W'(sq_root_reg[SQ_N-1][ROOT_W-1:Q_W]);
            assign q_prev   = '0;
            assign lo_prev  = sq_root_reg[SQ_N-1][Q_W-1:0];
        end else begin : g_body
            assign ctl_prev = dv_ctl_reg[j-1];
            assign rem_prev = dv_rem_reg[j-1];
            assign q_prev   = dv_q_reg[j-1];
            assign lo_prev  = dv_lo_reg[j-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev, lo_prev[B]};
            if (rem_sh >= {1'b0, size})
            begin
                rem_next = SIZE_W'(rem_sh - {1'b0, size});
                q_bit    = 1'b1;
            end
            else
            begin
                rem_next = rem_sh[SIZE_W-1:0];
                q_bit    = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_ctl_reg[j] <= '0;
            else
                dv_ctl_reg[j] <= ctl_prev;
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j] <= rem_next;
            dv_q_reg[j]   <= {q_prev[Q_W-2:0], q_bit};
            dv_lo_reg[j]  <= lo_prev;
        end
    end

    assign out_ctl = dv_ctl_reg[DV_N-1];
    assign out_t   = dv_q_reg[DV_N-1];

endmodule

// ===== hdl/bsfp_falloff.sv =====
// pipelined falloff power (1-t)^hardness through log2 and exp2 stages
module bsfp_falloff
    import bsfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsfp_ctl_t         in_ctl,
    input  logic [Q_W-1:0]    in_base,
    input  logic [EXPO_W-1:0] expo,
    output bsfp_ctl_t         out_ctl,
    output logic [Q_W-1:0]    out_edge
);

    // normalize stage
    logic       spec_in;
    logic       spec_one_in;
    logic [3:0] lz;
    logic [15:0] m_in;

    bsfp_ctl_t   f0_ctl_reg;
    logic        f0_spec_reg;
    logic        f0_one_reg;
    logic [3:0]  f0_n_reg;
    logic [15:0] f0_m_reg;

    always_comb
    begin
        spec_in     = (expo == '0) || (in_base == '0) || in_base[Q_W-1];
        spec_one_in = (expo == '0) || (in_base != '0);
        lz          = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (in_base[i])
                lz = 4'(15 - i);
        end
        m_in = in_base[15:0] << lz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f0_ctl_reg <= '0;
        else
            f0_ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        f0_spec_reg <= spec_in;
        f0_one_reg  <= spec_one_in;
        f0_n_reg    <= lz;
        f0_m_reg    <= m_in;
    end

    // log2 fraction, one bit per squaring
    bsfp_ctl_t   lg_ctl_reg  [LOG_STEPS];
    logic        lg_spec_reg [LOG_STEPS];
    logic        lg_one_reg  [LOG_STEPS];
    logic [3:0]  lg_n_reg    [LOG_STEPS];
    logic [15:0] lg_v_reg    [LOG_STEPS];
    logic [15:0] lg_f_reg    [LOG_STEPS];

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_lg
        bsfp_ctl_t   ctl_prev;
        logic        spec_prev;
        logic        one_prev;
        logic [3:0]  n_prev;
        logic [15:0] v_prev;
        logic [15:0] f_prev;
        logic [31:0] sq;
        logic [16:0] hi;
        logic [15:0] v_next;
        logic        f_bit;

        if (g == 0) begin : g_head
            assign ctl_prev  = f0_ctl_reg;
            assign spec_prev = f0_spec_reg;
            assign one_prev  = f0_one_reg;
            assign n_prev    = f0_n_reg;
            assign v_prev    = f0_m_reg;
            assign f_prev    = '0;
        end else begin : g_body
            assign ctl_prev  = lg_ctl_reg[g-1];
            assign spec_prev = lg_spec_reg[g-1];
            assign one_prev  = lg_one_reg[g-1];
            assign n_prev    = lg_n_reg[g-1];
            assign v_prev    = lg_v_reg[g-1];
            assign f_prev    = lg_f_reg[g-1];
        end

        always_comb
        begin
            sq = {16'b0, v_prev} * {16'b0, v_prev};
            hi = sq[31:15];
            if (hi[16])
            begin
                v_next = hi[16:1];
                f_bit  = 1'b1;
            end
            else
            begin
                v_next = hi[15:0];
                f_bit  = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lg_ctl_reg[g] <= '0;
            else
                lg_ctl_reg[g] <= ctl_prev;
        end

        always_ff @(posedge clk)
        begin
            lg_spec_reg[g] <= spec_prev;
            lg_one_reg[g]  <= one_prev;
            lg_n_reg[g]    <= n_prev;
            lg_v_reg[g]    <= v_next;
            lg_f_reg[g]    <= {f_prev[14:0], f_bit};
        end
    end

    // negative log2 and scaling by hardness
    bsfp_ctl_t   p1_ctl_reg;
    logic        p1_spec_reg;
    logic        p1_one_reg;
    logic [20:0] p1_nl_reg;
    bsfp_ctl_t   p2_ctl_reg;
    logic        p2_spec_reg;
    logic        p2_one_reg;
    logic [23:0] p2_p_reg;
    logic [32:0] p_full;

    assign p_full = {12'b0, p1_nl_reg} * {21'b0, expo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctl_reg <= '0;
            p2_ctl_reg <= '0;
        end
        else
        begin
            p1_ctl_reg <= lg_ctl_reg[LOG_STEPS-1];
            p2_ctl_reg <= p1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_spec_reg <= lg_spec_reg[LOG_STEPS-1];
        p1_one_reg  <= lg_one_reg[LOG_STEPS-1];
        p1_nl_reg   <= {({1'b0, lg_n_reg[LOG_STEPS-1]} + 5'd1), 16'b0}
                       - {5'b0, lg_f_reg[LOG_STEPS-1]};
        p2_spec_reg <= p1_spec_reg;
        p2_one_reg  <= p1_one_reg;
        p2_p_reg    <= p_full[31:8];
    end

    // exp2 of the negated fraction, one root of one half per stage
    bsfp_ctl_t   ex_ctl_reg  [EXP_STEPS];
    logic        ex_spec_reg [EXP_STEPS];
    logic        ex_one_reg  [EXP_STEPS];
    logic [4:0]  ex_k_reg    [EXP_STEPS];
    logic [15:0] ex_fr_reg   [EXP_STEPS];
    logic [31:0] ex_acc_reg  [EXP_STEPS];
    logic        ex_unit_reg [EXP_STEPS];

    for (genvar e = 0; e < EXP_STEPS; e++) begin : g_ex
        localparam logic [31:0] ROOT = exp_root(e + 1);
        bsfp_ctl_t   ctl_prev;
        logic        spec_prev;
        logic        one_prev;
        logic [4:0]  k_prev;
        logic [15:0] fr_prev;
        logic [31:0] acc_prev;
        logic        unit_prev;
        logic [63:0] prod;
        logic [31:0] acc_next;
        logic        unit_next;

        if (e == 0) begin : g_head
            logic k_big;
            assign k_big     = (p2_p_reg[23:16] >= 8'd17);
            assign ctl_prev  = p2_ctl_reg;
            assign spec_prev = p2_spec_reg || k_big;
            assign one_prev  = p2_spec_reg && p2_one_reg;
            assign k_prev    = p2_p_reg[20:16];
            assign fr_prev   = p2_p_reg[15:0];
            assign acc_prev  = '0;
            assign unit_prev = 1'b1;
        end else begin : g_body
            assign ctl_prev  = ex_ctl_reg[e-1];
            assign spec_prev = ex_spec_reg[e-1];
            assign one_prev  = ex_one_reg[e-1];
            assign k_prev    = ex_k_reg[e-1];
            assign fr_prev   = ex_fr_reg[e-1];
            assign acc_prev  = ex_acc_reg[e-1];
            assign unit_prev = ex_unit_reg[e-1];
        end

        always_comb
        begin
            prod      = 64'(acc_prev) * 64'(ROOT);
            acc_next  = acc_prev;
            unit_next = unit_prev;
            if (fr_prev[EXP_STEPS-1-e])
            begin
                unit_next = 1'b0;
                if (unit_prev)
                    acc_next = ROOT;
                else
                    acc_next = prod[63:32];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ex_ctl_reg[e] <= '0;
            else
                ex_ctl_reg[e] <= ctl_prev;
        end

        always_ff @(posedge clk)
        begin
            ex_spec_reg[e] <= spec_prev;
            ex_one_reg[e]  <= one_prev;
            ex_k_reg[e]    <= k_prev;
            ex_fr_reg[e]   <= fr_prev;
            ex_acc_reg[e]  <= acc_next;
            ex_unit_reg[e] <= unit_next;
        end
    end

    // final shift by the integer part
    bsfp_ctl_t      z_ctl_reg;
    logic [Q_W-1:0] z_edge_reg;
    logic [32:0]    acc_full;
    logic [Q_W-1:0] edge_next;

    always_comb
    begin
        acc_full = ex_unit_reg[EXP_STEPS-1] ? 33'h1_0000_0000
                                            : {1'b0, ex_acc_reg[EXP_STEPS-1]};
        if (ex_spec_reg[EXP_STEPS-1])
            edge_next = ex_one_reg[EXP_STEPS-1] ? Q_ONE : '0;
        else
            edge_next = acc_full[32:16] >> ex_k_reg[EXP_STEPS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z_ctl_reg <= '0;
        else
            z_ctl_reg <= ex_ctl_reg[EXP_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        z_edge_reg <= edge_next;
    end

    assign out_ctl  = z_ctl_reg;
    assign out_edge = z_edge_reg;

endmodule

// ===== hdl/brush_stamp_falloff_pixel.sv =====
// top level of the round brush stamp pixel generator with radial falloff
//
// one stamp pixel (pixel_x, pixel_y) goes in per cycle: an item is taken at
// each rising edge with start high and busy low; busy stays low, so a raster
// stream can be fed at full rate
// each item gives exactly one rgba result, shown for one cycle with done high;
// results leave in input order
// the pipeline has 3 distance stages, 25 square root stages, 17 divider
// stages, 36 falloff stages and 2 alpha stages
// pixels outside the disc come out all zero with inside_res low
// the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes size,
// hardness, opacity and the colour; cfg_ready is always high and writes are
// meant only while no item is in flight
// reset clears the pipeline valid bits and loads size 16, hardness 1.0,
// full opacity and black; the receiver cannot stall, nothing is held back
module brush_stamp_falloff_pixel
    import bsfp_pkg::*;
#(
    parameter int MAX_SIZE = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    pixel_x,
    input  logic [COORD_W-1:0]    pixel_y,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [COLOR_W-1:0]    red,
    output logic [COLOR_W-1:0]    green,
    output logic [COLOR_W-1:0]    blue,
    output logic [COLOR_W-1:0]    alpha,
    output logic                  inside_res
);

    localparam logic [SIZE_W-1:0] SIZE_LIMIT =
        (MAX_SIZE > 511) ? 9'd511 : SIZE_W'(MAX_SIZE);

    // configuration registers
    logic [SIZE_W-1:0]  brush_size_reg;
    logic [EXPO_W-1:0]  hardness_reg;
    logic [OPAC_W-1:0]  opacity_reg;
    logic [COLOR_W-1:0] color_red_reg;
    logic [COLOR_W-1:0] color_green_reg;
    logic [COLOR_W-1:0] color_blue_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_size_reg  <= 9'd16;
            hardness_reg    <= 12'd256;
            opacity_reg     <= 9'd256;
            color_red_reg   <= '0;
            color_green_reg <= '0;
            color_blue_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE:     brush_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HARDNESS: hardness_reg    <= cfg_data[EXPO_W-1:0];
                CFG_OPACITY:  opacity_reg     <= cfg_data[OPAC_W-1:0];
                CFG_RED:      color_red_reg   <= cfg_data[COLOR_W-1:0];
                CFG_GREEN:    color_green_reg <= cfg_data[COLOR_W-1:0];
                CFG_BLUE:     color_blue_reg  <= cfg_data[COLOR_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [SIZE_W-1:0]   size_eff;
    logic [2*SIZE_W-1:0] size_sq_reg;

    always_comb
    begin
        if (brush_size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (brush_size_reg > SIZE_LIMIT)
            size_eff = SIZE_LIMIT;
        else
            size_eff = brush_size_reg;
    end

    always_ff @(posedge clk)
    begin
        size_sq_reg <= {{SIZE_W{1'b0}}, size_eff} * {{SIZE_W{1'b0}}, size_eff};
    end

    // offsets from the center in half pixels
    bsfp_ctl_t          t0_ctl_reg;
    logic signed [10:0] t0_dx_reg;
    logic signed [10:0] t0_dy_reg;
    bsfp_ctl_t          t0_ctl_next;
    logic signed [10:0] dx_next;
    logic signed [10:0] dy_next;

    always_comb
    begin
        t0_ctl_next.valid = start && !busy;
        t0_ctl_next.hit   = ({1'b0, pixel_x} < size_eff) && ({1'b0, pixel_y} < size_eff);
        dx_next = $signed({2'b00, pixel_x, 1'b1}) - $signed({2'b00, size_eff});
        dy_next = $signed({2'b00, pixel_y, 1'b1}) - $signed({2'b00, size_eff});
    end

    // squares
    bsfp_ctl_t          t1_ctl_reg;
    logic [D_W-1:0]     t1_dxsq_reg;
    logic [D_W-1:0]     t1_dysq_reg;
    logic signed [21:0] dxsq_full;
    logic signed [21:0] dysq_full;

    assign dxsq_full = 22'(t0_dx_reg) * 22'(t0_dx_reg);
    assign dysq_full = 22'(t0_dy_reg) * 22'(t0_dy_reg);

    // distance and disc test
    bsfp_ctl_t      t2_ctl_reg;
    logic [D_W-1:0] t2_d_reg;
    logic [D_W:0]   d_sum;
    logic           in_disc;

    assign d_sum   = {1'b0, t1_dxsq_reg} + {1'b0, t1_dysq_reg};
    assign in_disc = t1_ctl_reg.hit && (d_sum <= {1'b0, size_sq_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_ctl_reg <= '0;
            t1_ctl_reg <= '0;
            t2_ctl_reg <= '0;
        end
        else
        begin
            t0_ctl_reg       <= t0_ctl_next;
            t1_ctl_reg       <= t0_ctl_reg;
            t2_ctl_reg.valid <= t1_ctl_reg.valid;
            t2_ctl_reg.hit   <= in_disc;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_dx_reg   <= dx_next;
        t0_dy_reg   <= dy_next;
        t1_dxsq_reg <= dxsq_full[D_W-1:0];
        t1_dysq_reg <= dysq_full[D_W-1:0];
        t2_d_reg    <= in_disc ? d_sum[D_W-1:0] : '0;
    end

    // radius ratio t in q1.16
    bsfp_ctl_t      rt_ctl;
    logic [Q_W-1:0] rt_t;

    bsfp_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (t2_ctl_reg),
        .in_d    (t2_d_reg),
        .size    (size_eff),
        .out_ctl (rt_ctl),
        .out_t   (rt_t)
    );

    // edge weight
    bsfp_ctl_t      fo_ctl;
    logic [Q_W-1:0] fo_edge;
    logic [Q_W-1:0] base;

    assign base = Q_ONE - rt_t;

    bsfp_falloff u_falloff (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (rt_ctl),
        .in_base  (base),
        .expo     (hardness_reg),
        .out_ctl  (fo_ctl),
        .out_edge (fo_edge)
    );

    // alpha
    bsfp_ctl_t   a1_ctl_reg;
    logic [25:0] a1_prod_reg;
    logic [33:0] scaled;
    logic [9:0]  alpha_raw;
    logic [7:0]  alpha_sat;

    always_comb
    begin
        scaled    = {a1_prod_reg, 8'b0} - {8'b0, a1_prod_reg};
        alpha_raw = scaled[33:24];
        alpha_sat = (alpha_raw[9:8] != 2'b00) ? 8'd255 : alpha_raw[7:0];
    end

    logic               done_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic [COLOR_W-1:0] alpha_reg;
    logic               inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a1_ctl_reg <= fo_ctl;
            done_reg   <= a1_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_prod_reg <= {17'b0, opacity_reg} * {9'b0, fo_edge};
        red_reg     <= a1_ctl_reg.hit ? color_red_reg : '0;
        green_reg   <= a1_ctl_reg.hit ? color_green_reg : '0;
        blue_reg    <= a1_ctl_reg.hit ? color_blue_reg : '0;
        alpha_reg   <= a1_ctl_reg.hit ? alpha_sat : '0;
        inside_reg  <= a1_ctl_reg.hit;
    end

    assign done       = done_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign inside_res = inside_reg;

endmodule

// ===== hdl/bsfp_checker.sv =====
// port-level checks of the brush stamp falloff block and their bind
module bsfp_checker
    import bsfp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [COLOR_W-1:0] red,
    input logic [COLOR_W-1:0] green,
    input logic [COLOR_W-1:0] blue,
    input logic [COLOR_W-1:0] alpha,
    input logic               inside_res
);

    // every accepted item gives a result
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item without result");

    // no result without an item
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without item");

    // pixels outside the disc are transparent black
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !inside_res) |->
            (red == '0 && green == '0 && blue == '0 && alpha == '0))
        else $error("outside pixel not zero");

endmodule

bind brush_stamp_falloff_pixel bsfp_checker u_bsfp_checker (.*);
